// File: rtl/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of the given clock, held off during reset.
`define VTQ_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Shorthand for the block clock and reset.
`define VTQ_ASSERT(label, prop, msg) \
    `VTQ_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// File: rtl/vtq_pkg.sv
// Shared types and constants of the virtual timer queue.
`timescale 1ns / 1ps

package vtq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDX_W       = $clog2(TIMER_SLOTS);
    localparam int ID_W        = 31;
    localparam int DUE_W       = 64;
    localparam int PER_W       = 31;
    localparam int BIRTH_W     = 32;
    localparam int DELAY_W     = 32;
    localparam int LIMIT_W     = 16;

    localparam logic [LIMIT_W-1:0] FIRE_LIMIT_RESET = LIMIT_W'(1024);
    localparam logic [ID_W-1:0]    ID_FIRST         = ID_W'(1);
    localparam logic [ID_W-1:0]    ID_MAX           = '1;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_FIRE  = 2'd2,
        KIND_RESET = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_LIMIT = 2'd3
    } status_t;

    // One timer slot as held in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DUE_W-1:0]   due;
        logic [PER_W-1:0]   period;
        logic [BIRTH_W-1:0] birth;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Scan control from the sequencer to the selector.
    typedef struct packed {
        logic               start;
        logic               vld;
        logic               fire;
        logic               live;
        logic [IDX_W-1:0]   idx;
        logic [ID_W-1:0]    want;
        logic [BIRTH_W-1:0] birth_now;
    } sel_ctrl_t;

    // Winner of a scan.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } sel_res_t;

endpackage

// File: rtl/virtual_timer_queue.sv
// Virtual timer queue: command sequencer, slot valid bits and result register.
// Set, reset and a fire refused at the limit go from accept straight to S_DONE;
// clear and other fires scan the slot memory one slot per cycle through its single
// read port, then pass S_DRAIN and S_FINISH before S_DONE. One word is worked on at a
// time; a new word is taken while the previous result still waits. Synchronous
// active-low reset empties the table, ids restart at 1, clock at 0, fire_limit 1024.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module virtual_timer_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [vtq_pkg::LIMIT_W-1:0]   cfg_wr_data,   // fire_limit
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,       // delay, repeat_req, timer_id
    input  logic [1:0]                    s_tuser,       // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,       // new_id, fired_id, fired_rearmed,
                                                         // time_now, zero pad
    output logic [1:0]                    m_tuser        // status
);

    import vtq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_FINISH = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [ID_W-1:0]        next_id_reg;
    logic [DUE_W-1:0]       now_reg;
    logic [LIMIT_W-1:0]     fires_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [BIRTH_W-1:0]     birth_cnt_reg;
    logic                   cmd_fire_reg;
    logic [ID_W-1:0]        want_reg;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;

    status_t                res_status_reg;
    logic [ID_W-1:0]        res_new_id_reg;
    logic [ID_W-1:0]        res_fired_id_reg;
    logic                   res_rearmed_reg;

    logic                   m_tvalid_reg;
    status_t                m_status_reg;
    logic [ID_W-1:0]        m_new_id_reg;
    logic [ID_W-1:0]        m_fired_id_reg;
    logic                   m_rearmed_reg;
    logic [DUE_W-1:0]       m_now_reg;

    kind_t                  in_kind;
    logic [DELAY_W-1:0]     in_delay;
    logic                   in_repeat;
    logic [ID_W-1:0]        in_id;
    logic                   accept;
    logic [DELAY_W-1:0]     delay_clamp;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   limit_hit;
    logic                   out_free;
    logic                   rearm;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wdata;
    entry_t                 ram_rdata;
    sel_ctrl_t              sel_ctrl;
    sel_res_t               sel_res;

    assign in_kind     = kind_t'(s_tuser);
    assign in_delay    = s_tdata[31:0];
    assign in_repeat   = s_tdata[32];
    assign in_id       = s_tdata[63:33];
    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign delay_clamp = in_delay[DELAY_W-1] ? '0 : in_delay;
    assign limit_hit   = (fires_reg >= limit_reg);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign rearm       = sel_res.entry.period != '0;

    // lowest-numbered free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata.id     = next_id_reg;
        ram_wdata.due    = now_reg + DUE_W'(delay_clamp);
        ram_wdata.period = in_repeat ? delay_clamp[PER_W-1:0] : '0;
        ram_wdata.birth  = birth_cnt_reg;
        if (accept && in_kind == KIND_SET && free_found) begin
            ram_we = 1'b1;
        end else if (state_reg == S_FINISH && cmd_fire_reg && sel_res.found && rearm) begin
            ram_we           = 1'b1;
            ram_waddr        = sel_res.idx;
            ram_wdata        = sel_res.entry;
            ram_wdata.due    = sel_res.entry.due + DUE_W'(sel_res.entry.period);
        end
    end

    vtq_ram #(
        .DEPTH (TIMER_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == S_SCAN),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        sel_ctrl.start     = accept;
        sel_ctrl.vld       = cmp_vld_reg;
        sel_ctrl.fire      = cmd_fire_reg;
        sel_ctrl.live      = valid_reg[cmp_idx_reg];
        sel_ctrl.idx       = cmp_idx_reg;
        sel_ctrl.want      = want_reg;
        sel_ctrl.birth_now = birth_cnt_reg;
    end

    vtq_select u_select (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (sel_ctrl),
        .rd_entry (ram_rdata),
        .res      (sel_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if ((in_kind == KIND_CLEAR) || (in_kind == KIND_FIRE && !limit_hit)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (rd_addr_reg == IDX_W'(TIMER_SLOTS - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_FINISH;
            S_FINISH: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            next_id_reg   <= ID_FIRST;
            now_reg       <= '0;
            fires_reg     <= '0;
            limit_reg     <= FIRE_LIMIT_RESET;
            birth_cnt_reg <= '0;
            rd_addr_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == S_SCAN);
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (state_reg == S_SCAN) begin
                rd_addr_reg <= rd_addr_reg + IDX_W'(1);
            end else begin
                rd_addr_reg <= '0;
            end
            if (accept) begin
                case (in_kind)
                    KIND_SET: begin
                        if (free_found) begin
                            valid_reg[free_idx] <= 1'b1;
                            birth_cnt_reg       <= birth_cnt_reg + BIRTH_W'(1);
                            next_id_reg <= (next_id_reg == ID_MAX) ? ID_FIRST
                                                                   : next_id_reg + ID_W'(1);
                        end
                    end
                    KIND_RESET: begin
                        valid_reg     <= '0;
                        next_id_reg   <= ID_FIRST;
                        now_reg       <= '0;
                        fires_reg     <= '0;
                        birth_cnt_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_FINISH && sel_res.found) begin
                if (cmd_fire_reg) begin
                    now_reg   <= sel_res.entry.due;
                    fires_reg <= fires_reg + LIMIT_W'(1);
                    if (!rearm) begin
                        valid_reg[sel_res.idx] <= 1'b0;
                    end
                end else begin
                    valid_reg[sel_res.idx] <= 1'b0;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_addr_reg;
        if (accept) begin
            cmd_fire_reg     <= (in_kind == KIND_FIRE);
            want_reg         <= in_id;
            res_status_reg   <= ST_OK;
            res_new_id_reg   <= '0;
            res_fired_id_reg <= '0;
            res_rearmed_reg  <= 1'b0;
            case (in_kind)
                KIND_SET: begin
                    if (free_found) begin
                        res_new_id_reg <= next_id_reg;
                    end else begin
                        res_status_reg <= ST_FULL;
                    end
                end
                KIND_FIRE: begin
                    if (limit_hit) begin
                        res_status_reg <= ST_LIMIT;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_FINISH && cmd_fire_reg) begin
            if (sel_res.found) begin
                res_fired_id_reg <= sel_res.entry.id;
                res_rearmed_reg  <= rearm;
            end else begin
                res_status_reg <= ST_EMPTY;
            end
        end
        if (state_reg == S_DONE && out_free) begin
            m_status_reg   <= res_status_reg;
            m_new_id_reg   <= res_new_id_reg;
            m_fired_id_reg <= res_fired_id_reg;
            m_rearmed_reg  <= res_rearmed_reg;
            m_now_reg      <= now_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_now_reg, m_rearmed_reg, m_fired_id_reg, m_new_id_reg};

    `VTQ_ASSERT(a_result_from_done, $rose(m_tvalid) |-> $past(state_reg == S_DONE), "result word without completed command")
    `VTQ_ASSERT(a_full_means_full, (state_reg == S_DONE && res_status_reg == ST_FULL) |-> (&valid_reg), "table full reported with a free slot")
    `VTQ_ASSERT(a_cmp_in_scan, cmp_vld_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN), "slot compare outside a scan")

endmodule

// File: rtl/vtq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module vtq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/vtq_select.sv
// Scan selector: keeps the best slot seen so far, one slot word per cycle.
`timescale 1ns / 1ps

module vtq_select (
    input  logic              aclk,
    input  logic              aresetn,
    input  vtq_pkg::sel_ctrl_t ctrl,
    input  vtq_pkg::entry_t   rd_entry,
    output vtq_pkg::sel_res_t res
);

    import vtq_pkg::*;

    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    entry_t             best_entry_reg;
    logic [BIRTH_W-1:0] best_age_reg;

    logic [BIRTH_W-1:0] age;
    logic               match;
    logic               due_less;
    logic               due_same;
    logic               age_less;
    logic               better;
    logic               take;

    always_comb begin
        // age wraps modulo 2^32; youngest wins ties
        age      = ctrl.birth_now - rd_entry.birth;
        match    = ctrl.live && (ctrl.fire || (rd_entry.id == ctrl.want));
        due_less = rd_entry.due < best_entry_reg.due;
        due_same = rd_entry.due == best_entry_reg.due;
        age_less = age < best_age_reg;
        better   = !found_reg ||
                   (ctrl.fire ? (due_less || (due_same && age_less)) : age_less);
        take     = ctrl.vld && match && better;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg   <= ctrl.idx;
            best_entry_reg <= rd_entry;
            best_age_reg   <= age;
        end
    end

    assign res.found = found_reg;
    assign res.idx   = best_idx_reg;
    assign res.entry = best_entry_reg;

endmodule
